FILE: hw/rtl/crc16c_pkg.sv
// Package with shared types, constants and the byte fold function of the CRC-16 engine.
package crc16c_pkg;

	localparam int CRC_W      = 16;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_POLY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd2;

	localparam logic [CRC_W-1:0] POLY_RESET = 16'h1021;
	localparam logic [CRC_W-1:0] SEED_RESET = 16'h0000;
	localparam logic             MODE_RESET = 1'b0;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(QDEPTH);
	localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(QDEPTH - 1);

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              first_byte;
		logic              last_byte;
	} in_t;

	typedef struct packed {
		logic [CRC_W-1:0] crc_value;
		logic             message_end;
	} out_t;

	typedef struct packed {
		logic valid;
		in_t  item;
	} fq_t;

	function automatic logic [CRC_W-1:0] crc16c_fold(
		input logic [CRC_W-1:0]  crc,
		input logic [BYTE_W-1:0] b,
		input logic [CRC_W-1:0]  poly,
		input logic              refl
	);
		logic [CRC_W-1:0] c;
		c = refl ? (crc ^ {8'h00, b}) : (crc ^ {b, 8'h00});
		for (int k = 0; k < BYTE_W; k++) begin
			if (refl) begin
				c = c[0] ? ({1'b0, c[CRC_W-1:1]} ^ poly) : {1'b0, c[CRC_W-1:1]};
			end else begin
				c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ poly) : {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/crc16c_front.sv
// Front stage: accepts byte requests into a short queue that feeds the CRC stage.
module crc16c_front import crc16c_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_t  item,
	output fq_t  fq,
	input  logic take
);

	in_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (cnt_q == QCNT_FULL);
	assign do_push  = push && !full;
	assign do_pop   = take && (cnt_q != '0);
	assign fq.valid = (cnt_q != '0);
	assign fq.item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == QPTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == QPTR_LAST) ? '0 : rd_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/crc16c_core.sv
// Back stage: folds each byte into the CRC register and queues the results.
module crc16c_core import crc16c_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  fq_t              fq,
	output logic             take,
	input  logic [CRC_W-1:0] poly,
	input  logic [CRC_W-1:0] seed,
	input  logic             refl,
	output logic             empty,
	input  logic             pop,
	output out_t             result
);

	logic [CRC_W-1:0]  crc_q;
	logic [CRC_W-1:0]  crc_start;
	logic [CRC_W-1:0]  crc_next;
	out_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign take      = fq.valid && (cnt_q != QCNT_FULL);
	assign crc_start = fq.item.first_byte ? seed : crc_q;
	assign crc_next  = crc16c_fold(crc_start, fq.item.data_byte, poly, refl);
	assign empty     = (cnt_q == '0);
	assign do_pop    = pop && !empty;
	assign result    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (take) begin
			mem_q[wr_q] <= '{crc_value: crc_next, message_end: fq.item.last_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (take) begin
				crc_q <= crc_next;
				wr_q  <= (wr_q == QPTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == QPTR_LAST) ? '0 : rd_q + 1'b1;
			end
			unique case ({take, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/crc16_configurable_bytewise.sv
// Top level of the configurable bytewise CRC-16 engine.
// One byte request enters per clock and one CRC result leaves per clock when
// neither side stalls; the limit is the CRC stage, which folds a whole byte
// (eight shift steps) into the register combinationally. A result becomes
// visible once its byte has passed both queues: the byte sits at the head of
// the input queue until the CRC stage takes it and writes its result into the
// output queue. Each result is the CRC register after its byte, with no final
// XOR. Configuration should be written only while no byte is in flight.
module crc16_configurable_bytewise import crc16c_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  in_t                   item,
	output logic                  empty,
	input  logic                  pop,
	output out_t                  result,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [CRC_W-1:0] poly_q;
	logic [CRC_W-1:0] seed_q;
	logic             mode_q;
	fq_t              fq;
	logic             take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= POLY_RESET;
			seed_q <= SEED_RESET;
			mode_q <= MODE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_POLY: poly_q <= cfg_data[CRC_W-1:0];
				REG_SEED: seed_q <= cfg_data[CRC_W-1:0];
				REG_MODE: mode_q <= cfg_data[0];
				default:  mode_q <= mode_q;
			endcase
		end
	end

	crc16c_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.fq     (fq),
		.take   (take)
	);

	crc16c_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fq     (fq),
		.take   (take),
		.poly   (poly_q),
		.seed   (seed_q),
		.refl   (mode_q),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> fq.valid)
		else $error("CRC stage took a request from an empty front queue.");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fq.valid && !take) |=> (fq.valid && $stable(fq.item)))
		else $error("Front queue head changed while the CRC stage stalled.");

	a_mode_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(cfg_write && (cfg_index == REG_MODE)) |=> $stable(mode_q))
		else $error("Bit order changed without a write to its register.");

endmodule
